>>> design/particle_sensor_frame_parser_top_macros.svh
// assertion macros for the particle sensor frame parser checker
`ifndef PARTICLE_SENSOR_FRAME_PARSER_TOP_MACROS_SVH
`define PARTICLE_SENSOR_FRAME_PARSER_TOP_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define PSFP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define PSFP_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/psfp_pkg.sv
// shared types and constants of the particle sensor frame parser
`timescale 1ns / 1ps
`default_nettype none

package psfp_pkg;

  localparam int WORD_COUNT = 13;
  localparam int IDX_W      = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  localparam int OUT_IDX_W  = 4;

  localparam logic [7:0]  START_A   = 8'h42;
  localparam logic [7:0]  START_B   = 8'h4D;
  localparam logic [15:0] LEN_RESET = 16'h001C;

  localparam logic KIND_WORD = 1'b0;
  localparam logic KIND_ERR  = 1'b1;

  typedef enum logic [2:0] {
    PH_HUNT   = 3'd0,
    PH_START2 = 3'd1,
    PH_LENHI  = 3'd2,
    PH_LENLO  = 3'd3,
    PH_DATAHI = 3'd4,
    PH_DATALO = 3'd5,
    PH_SUMHI  = 3'd6,
    PH_SUMLO  = 3'd7
  } psfp_phase_t;

  // parser to readout unit
  typedef struct packed {
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
    logic [15:0]      wr_data;
    logic             go;
    logic             err;
    logic [15:0]      err_val;
    logic [15:0]      sum;
  } psfp_cmd_t;

  // readout unit to parser
  typedef struct packed {
    logic burst_busy;
    logic out_busy;
  } psfp_stat_t;

endpackage

`default_nettype wire

>>> design/psfp_burst.sv
// word store memory, burst readout and result register
`timescale 1ns / 1ps
`default_nettype none

module psfp_burst
  import psfp_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire psfp_cmd_t            cmd,
  output psfp_stat_t                stat,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic                      out_kind,
  output logic [OUT_IDX_W-1:0]      out_word_index,
  output logic [15:0]               out_word_value,
  output logic [15:0]               out_computed_sum,
  output logic                      out_last
);

  logic [15:0]          mem_r [WORD_COUNT];
  logic [15:0]          rd_data_r;
  logic [IDX_W-1:0]     rd_idx_r, rd_idx_nxt;
  logic [IDX_W-1:0]     pend_idx_r;
  logic                 burst_r, burst_nxt;
  logic                 rd_pend_r;
  logic [15:0]          sum_r;
  logic                 out_valid_r, out_valid_nxt;
  logic                 kind_r;
  logic [OUT_IDX_W-1:0] idx_r;
  logic [15:0]          val_r;
  logic [15:0]          csum_r;
  logic                 last_r;
  logic                 out_acc;
  logic                 issue;

  assign out_acc = out_valid_r && !out_stall;
  // one read in flight at a time, issued only when the result register will be free
  assign issue   = burst_r && !rd_pend_r && (!out_valid_r || out_acc);

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem_r[cmd.wr_idx] <= cmd.wr_data;
    end
    if (issue) begin
      rd_data_r  <= mem_r[rd_idx_r];
      pend_idx_r <= rd_idx_r;
    end
    if (cmd.go) begin
      sum_r <= cmd.sum;
    end
  end

  always_comb begin
    rd_idx_nxt = rd_idx_r;
    burst_nxt  = burst_r;
    priority if (cmd.go) begin
      rd_idx_nxt = '0;
      burst_nxt  = 1'b1;
    end else if (issue) begin
      rd_idx_nxt = rd_idx_r + 1'b1;
      if (rd_idx_r == IDX_W'(WORD_COUNT - 1)) begin
        burst_nxt = 1'b0;
      end
    end else begin
      rd_idx_nxt = rd_idx_r;
      burst_nxt  = burst_r;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    priority if (rd_pend_r || cmd.err) begin
      out_valid_nxt = 1'b1;
    end else if (out_acc) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_idx_r    <= '0;
      burst_r     <= 1'b0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rd_idx_r    <= rd_idx_nxt;
      burst_r     <= burst_nxt;
      rd_pend_r   <= issue;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    priority if (rd_pend_r) begin
      kind_r <= KIND_WORD;
      idx_r  <= OUT_IDX_W'(pend_idx_r);
      val_r  <= rd_data_r;
      csum_r <= sum_r;
      last_r <= (pend_idx_r == IDX_W'(WORD_COUNT - 1));
    end else if (cmd.err) begin
      kind_r <= KIND_ERR;
      idx_r  <= '0;
      val_r  <= cmd.err_val;
      csum_r <= cmd.sum;
      last_r <= 1'b1;
    end else begin
      kind_r <= kind_r;
      idx_r  <= idx_r;
      val_r  <= val_r;
      csum_r <= csum_r;
      last_r <= last_r;
    end
  end

  assign stat.burst_busy = burst_r || rd_pend_r;
  assign stat.out_busy   = out_valid_r;

  assign out_valid        = out_valid_r;
  assign out_kind         = kind_r;
  assign out_word_index   = idx_r;
  assign out_word_value   = val_r;
  assign out_computed_sum = csum_r;
  assign out_last         = last_r;

endmodule

`default_nettype wire

>>> design/particle_sensor_frame_parser_top.sv
// particle sensor frame parser: byte parser with checksum and word store readout
//
//   channel  | direction | handshake            | payload
//   in_      | input     | in_valid / in_stall  | in_rx_byte
//   out_     | output    | out_valid / out_stall| kind, word_index, word_value, computed_sum, last
//   cfg_     | input     | cfg_wr_en            | cfg_wr_data (expected frame length)
//
// one byte is taken per cycle unless in_stall is high; the parser updates its state in the same cycle
// a good frame drains 13 words from the word store with one read in flight at a time (memory read then
// result register, held by out_stall); data bytes and the checksum low byte stall while that burst runs
// a checksum low byte also stalls while a result waits in the result register
// reset (synchronous, active low) returns to hunting and sets expected length to 28
`timescale 1ns / 1ps
`default_nettype none

module particle_sensor_frame_parser_top
  import psfp_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [7:0]           in_rx_byte,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic                      out_kind,
  output logic [OUT_IDX_W-1:0]      out_word_index,
  output logic [15:0]               out_word_value,
  output logic [15:0]               out_computed_sum,
  output logic                      out_last,
  input  wire logic                 cfg_wr_en,
  input  wire logic [15:0]          cfg_wr_data
);

  psfp_phase_t      phase_r, phase_nxt;
  logic [15:0]      sum_r, sum_nxt;
  logic [7:0]       hi_r, hi_nxt;
  logic [IDX_W-1:0] cnt_r, cnt_nxt;
  logic [15:0]      cfg_len_r;
  logic             in_acc;
  logic [15:0]      byte_word;
  psfp_cmd_t        cmd;
  psfp_stat_t       stat;

  // data writes and a new burst must wait for the previous burst to drain
  always_comb begin
    unique case (phase_r)
      PH_DATAHI, PH_DATALO: in_stall = stat.burst_busy;
      PH_SUMLO:             in_stall = stat.burst_busy || stat.out_busy;
      default:              in_stall = 1'b0;
    endcase
  end

  assign in_acc    = in_valid && !in_stall;
  assign byte_word = {hi_r, in_rx_byte};

  always_comb begin
    phase_nxt   = phase_r;
    sum_nxt     = sum_r;
    hi_nxt      = hi_r;
    cnt_nxt     = cnt_r;
    cmd         = '0;
    cmd.wr_idx  = cnt_r;
    cmd.wr_data = byte_word;
    cmd.err_val = byte_word;
    cmd.sum     = sum_r;
    if (in_acc) begin
      unique case (phase_r)
        PH_HUNT: begin
          sum_nxt = {8'h00, in_rx_byte};
          if (in_rx_byte == START_A) begin
            phase_nxt = PH_START2;
          end
        end
        PH_START2: begin
          sum_nxt   = sum_r + {8'h00, in_rx_byte};
          phase_nxt = (in_rx_byte == START_B) ? PH_LENHI : PH_HUNT;
        end
        PH_LENHI: begin
          sum_nxt   = sum_r + {8'h00, in_rx_byte};
          hi_nxt    = in_rx_byte;
          phase_nxt = PH_LENLO;
        end
        PH_LENLO: begin
          sum_nxt   = sum_r + {8'h00, in_rx_byte};
          cnt_nxt   = '0;
          phase_nxt = (byte_word == cfg_len_r) ? PH_DATAHI : PH_HUNT;
        end
        PH_DATAHI: begin
          sum_nxt   = sum_r + {8'h00, in_rx_byte};
          hi_nxt    = in_rx_byte;
          phase_nxt = PH_DATALO;
        end
        PH_DATALO: begin
          sum_nxt   = sum_r + {8'h00, in_rx_byte};
          cmd.wr_en = 1'b1;
          cnt_nxt   = cnt_r + 1'b1;
          phase_nxt = (cnt_r == IDX_W'(WORD_COUNT - 1)) ? PH_SUMHI : PH_DATAHI;
        end
        PH_SUMHI: begin
          hi_nxt    = in_rx_byte;
          phase_nxt = PH_SUMLO;
        end
        PH_SUMLO: begin
          phase_nxt = PH_HUNT;
          if (byte_word == sum_r) begin
            cmd.go = 1'b1;
          end else begin
            cmd.err = 1'b1;
          end
        end
        default: phase_nxt = PH_HUNT;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HUNT;
      sum_r     <= '0;
      hi_r      <= '0;
      cnt_r     <= '0;
      cfg_len_r <= LEN_RESET;
    end else begin
      phase_r <= phase_nxt;
      sum_r   <= sum_nxt;
      hi_r    <= hi_nxt;
      cnt_r   <= cnt_nxt;
      if (cfg_wr_en) begin
        cfg_len_r <= cfg_wr_data;
      end
    end
  end

  psfp_burst u_burst (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_kind         (out_kind),
    .out_word_index   (out_word_index),
    .out_word_value   (out_word_value),
    .out_computed_sum (out_computed_sum),
    .out_last         (out_last)
  );

endmodule

`default_nettype wire

>>> design/psfp_checker.sv
// port-level checker for the particle sensor frame parser, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

`include "particle_sensor_frame_parser_top_macros.svh"

module psfp_checker
  import psfp_pkg::*;
(
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 out_valid,
  input wire logic                 out_stall,
  input wire logic                 out_kind,
  input wire logic [OUT_IDX_W-1:0] out_word_index,
  input wire logic [15:0]          out_word_value,
  input wire logic                 out_last
);

  `PSFP_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_word_value) && $stable(out_kind), "result changed while stalled")

  `PSFP_ASSERT_IMP(a_err_shape, clk, rst_n, out_valid && (out_kind == KIND_ERR), out_last && (out_word_index == '0), "error transaction not single and last")

  `PSFP_ASSERT_IMP(a_word_last, clk, rst_n, out_valid && (out_kind == KIND_WORD), out_last == (out_word_index == OUT_IDX_W'(WORD_COUNT - 1)), "last flag not on final word")

endmodule

bind particle_sensor_frame_parser_top psfp_checker u_psfp_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_kind       (out_kind),
  .out_word_index (out_word_index),
  .out_word_value (out_word_value),
  .out_last       (out_last)
);

`default_nettype wire
